// ===== src/bcss_pkg.sv =====
package bcss_pkg;

   localparam int unsigned TimeWidth     = 32;
   localparam int unsigned CfgWidth      = 16;
   localparam int unsigned StepWidth     = 2;
   localparam int unsigned StepCount     = 4;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned ReqDataWidth  = 40;
   localparam int unsigned RspDataWidth  = 24;

   typedef logic [CfgWidth-1:0]  cfg_word_type;
   typedef logic [TimeWidth-1:0] time_type;
   typedef logic [StepWidth-1:0] step_type;

   typedef enum logic [1:0] {
      REASON_START  = 2'd0,
      REASON_FWD    = 2'd1,
      REASON_BACK   = 2'd2
   } reason_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DEBOUNCE  = 3'd0,
      CSR_DOUBLE    = 3'd1,
      CSR_INTERVAL0 = 3'd2,
      CSR_INTERVAL1 = 3'd3,
      CSR_INTERVAL2 = 3'd4,
      CSR_INTERVAL3 = 3'd5
   } csr_index_type;

   localparam cfg_word_type DebounceReset = 16'd25;
   localparam cfg_word_type DoubleReset   = 16'd300;
   localparam cfg_word_type Interval0Rst  = 16'd250;
   localparam cfg_word_type Interval1Rst  = 16'd500;
   localparam cfg_word_type Interval2Rst  = 16'd1000;
   localparam cfg_word_type Interval3Rst  = 16'd2000;

endpackage

// ===== src/button_click_step_selector.sv =====
// Debounced click step selector. One button poll sample (pressed level and a
// wrapping millisecond timestamp) is taken per req beat, one beat per clock
// while req_tready is high. A sample passes an input register, then compare
// logic updates the click state and, when the step index moves or on the first
// sample after reset, loads one rsp beat (interval, step index, reason) into
// the result register, which drives rsp_tvalid. The input stage holds while
// the result register is full and not being taken, so throughput is one
// sample per cycle as long as rsp_tready stays high.
// Configuration registers are written through the csr port, which is always
// ready; write them only while no sample is in flight.
module button_click_step_selector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] raw_down, [32:1] now_time, [39:33] zero
   input  logic [bcss_pkg::ReqDataWidth-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [15:0] interval_out, [17:16] step_out, [19:18] reason_code, [23:20] zero
   output logic [bcss_pkg::RspDataWidth-1:0]    rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bcss_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [bcss_pkg::CfgWidth-1:0]        csr_data
);
   import bcss_pkg::*;

   // configuration
   cfg_word_type debounce_ff;
   cfg_word_type double_gap_ff;
   cfg_word_type interval_ff [StepCount];

   // input stage
   logic     in_valid_ff;
   logic     in_down_ff;
   time_type in_now_ff;

   // click state
   logic     pressed_ff, pressed_in;
   time_type last_edge_ff, last_edge_in;
   time_type last_rel_ff, last_rel_in;
   logic     pending_ff, pending_in;
   step_type step_ff, step_in;
   logic     announced_ff;

   // result register
   logic         out_valid_ff;
   cfg_word_type out_interval_ff;
   step_type     out_step_ff;
   reason_type   out_reason_ff;

   logic       advance;
   logic       emit;
   reason_type reason_in;
   time_type   edge_diff;
   time_type   gap_diff;
   logic       edge_ok, release_hit, double_hit, fwd_hit, pend_mid;

   assign csr_ready  = 1'b1;
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth - CfgWidth - 2 * StepWidth){1'b0}},
                        out_reason_ff, out_step_ff, out_interval_ff};

   always_comb begin
      edge_diff   = in_now_ff - last_edge_ff;
      edge_ok     = (in_down_ff != pressed_ff) &&
                    (edge_diff >= {{(TimeWidth - CfgWidth){1'b0}}, debounce_ff});
      release_hit = edge_ok && !in_down_ff;
      double_hit  = release_hit && pending_ff;
      pend_mid    = release_hit ? !pending_ff : pending_ff;
      pressed_in  = edge_ok ? in_down_ff : pressed_ff;
      last_edge_in = edge_ok ? in_now_ff : last_edge_ff;
      last_rel_in  = release_hit ? in_now_ff : last_rel_ff;
      // a release in this sample leaves zero elapsed gap time
      gap_diff    = release_hit ? '0 : (in_now_ff - last_rel_ff);
      fwd_hit     = pend_mid && !pressed_in &&
                    (gap_diff >= {{(TimeWidth - CfgWidth){1'b0}}, double_gap_ff});
      pending_in  = pend_mid && !fwd_hit;
      if (double_hit) begin
         step_in = step_ff - step_type'(1);
      end else if (fwd_hit) begin
         step_in = step_ff + step_type'(1);
      end else begin
         step_in = step_ff;
      end
      emit = !announced_ff || double_hit || fwd_hit;
      if (fwd_hit) begin
         reason_in = REASON_FWD;
      end else if (double_hit) begin
         reason_in = REASON_BACK;
      end else begin
         reason_in = REASON_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DebounceReset;
         double_gap_ff  <= DoubleReset;
         interval_ff[0] <= Interval0Rst;
         interval_ff[1] <= Interval1Rst;
         interval_ff[2] <= Interval2Rst;
         interval_ff[3] <= Interval3Rst;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_DEBOUNCE:  debounce_ff    <= csr_data;
            CSR_DOUBLE:    double_gap_ff  <= csr_data;
            CSR_INTERVAL0: interval_ff[0] <= csr_data;
            CSR_INTERVAL1: interval_ff[1] <= csr_data;
            CSR_INTERVAL2: interval_ff[2] <= csr_data;
            CSR_INTERVAL3: interval_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_down_ff <= req_tdata[0];
         in_now_ff  <= req_tdata[TimeWidth:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressed_ff   <= 1'b0;
         last_edge_ff <= '0;
         last_rel_ff  <= '0;
         pending_ff   <= 1'b0;
         step_ff      <= '0;
         announced_ff <= 1'b0;
      end else if (advance) begin
         pressed_ff   <= pressed_in;
         last_edge_ff <= last_edge_in;
         last_rel_ff  <= last_rel_in;
         pending_ff   <= pending_in;
         step_ff      <= step_in;
         announced_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         out_interval_ff <= interval_ff[step_in];
         out_step_ff     <= step_in;
         out_reason_ff   <= reason_in;
      end
   end

`ifndef SYNTHESIS
   // the step index only moves together with a result beat
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(step_ff)) |-> $past(advance && emit))
      else $error("step index changed without a result beat");

   // once announced, stays announced until reset
   assert property (@(posedge clock) disable iff (reset)
      announced_ff |=> announced_ff)
      else $error("start announcement flag dropped");

   // the start beat always reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_reason_ff == REASON_START) |-> (out_step_ff == '0))
      else $error("start beat with nonzero step index");
`endif

endmodule
